[rtl/assert_macros.svh]
// Assertion macros shared by the flanger RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("flanger assertion failed");
`define ASSERT_NEVER(lbl, expr, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("flanger forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop, clk, rst_n)
`define ASSERT_NEVER(lbl, expr, clk, rst_n)
`endif
`endif

[rtl/mdf_pkg.sv]
// Types, constants and the quarter-wave cosine ROM of the flanger.
// No dependencies; imported by every module of the block.
package mdf_pkg;

  localparam int COS_N       = 256;
  localparam int COS_IDX_W   = $clog2(COS_N) + 1;
  localparam int PHASE_POS_W = $clog2(COS_N) + 2;
  localparam int COS_W       = 15;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PC_A    = 64'sd1324675879;
  localparam longint PC_B    = 64'sd272375560;
  localparam longint PC_C    = 64'sd22401992;
  localparam longint PC_D    = 64'sd987048;
  localparam longint PC_E    = 64'sd27060;

  localparam logic [9:0]  BASE_DELAY_RST  = 10'd441;
  localparam logic [9:0]  SWEEP_DEPTH_RST = 10'd441;
  localparam logic [31:0] PHASE_STEP_RST  = 32'd194783;
  localparam logic [15:0] MIX_GAIN_RST    = 16'd16384;

  typedef enum logic [1:0] {
    REG_BASE_DELAY,
    REG_SWEEP_DEPTH,
    REG_PHASE_STEP,
    REG_MIX_GAIN
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TAP,
    ST_GAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [9:0]  base_delay;
    logic [9:0]  sweep_depth;
    logic [31:0] phase_step;
    logic [15:0] mix_gain;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic tap_en;
    logic gain_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  typedef logic [COS_N:0][COS_W-1:0] cos_tab_t;

  // Entry k is cos(k*pi/(2*COS_N)) in unsigned Q0.15 from an even polynomial in Q30.
  function automatic logic [COS_W-1:0] cos_entry(int k);
    longint t;
    longint u;
    longint h;
    longint v;
    t = (longint'(k) <<< 30) / COS_N;
    u = (t * t) / Q30_ONE;
    h = PC_E;
    h = PC_D - (u * h) / Q30_ONE;
    h = PC_C - (u * h) / Q30_ONE;
    h = PC_B - (u * h) / Q30_ONE;
    h = PC_A - (u * h) / Q30_ONE;
    v = Q30_ONE - (u * h) / Q30_ONE;
    if (v < 0) begin
      v = 0;
    end
    v = (v + 64'sd16384) / 64'sd32768;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return COS_W'(v);
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    for (int k = 0; k <= COS_N; k++) begin
      tab[k] = cos_entry(k);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

[rtl/modulated_delay_flanger_unit.sv]
// Top level of the flanger: register file, controller and datapath.
// Depends on mdf_pkg, mdf_cfg, mdf_ctrl and mdf_dp.
//
//  Channel | Dir | Handshake                  | Payload
//  --------+-----+----------------------------+--------------------------
//  input   | in  | in_valid_i / in_stall_o    | sample_in_i  (s16 Q1.15)
//  output  | out | out_valid_o / out_stall_i  | sample_out_o (s16 Q1.15)
//  config  | in  | psel, penable, pwrite ...  | pwdata, paddr, prdata
//
// Each sample passes from its input transfer through the sweep multiply, the
// ring tap read, the gain multiply and the output load, all through one shared
// sequencer, which waits before the load while the output register is held, so
// no new sample is taken until the previous result has been loaded.
// The next sample is taken as soon as the result sits in the output register,
// even while the downstream side stalls it. Reset clears the pointer, phase,
// warm-up count and output valid; the delay ring is not cleared.
module modulated_delay_flanger_unit #(
  parameter int RING_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sample_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mdf_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  mdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mdf_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

endmodule

[rtl/mdf_cfg.sv]
// APB-style register file holding the four flanger settings.
// Depends on mdf_pkg for the register indexes, reset values and cfg_t.
module mdf_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mdf_pkg::cfg_t cfg_o
);
  import mdf_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_BASE_DELAY:  cfg_d.base_delay  = pwdata[9:0];
        REG_SWEEP_DEPTH: cfg_d.sweep_depth = pwdata[9:0];
        REG_PHASE_STEP:  cfg_d.phase_step  = pwdata;
        REG_MIX_GAIN:    cfg_d.mix_gain    = pwdata[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_DELAY:  prdata = {22'd0, cfg_q.base_delay};
      REG_SWEEP_DEPTH: prdata = {22'd0, cfg_q.sweep_depth};
      REG_PHASE_STEP:  prdata = cfg_q.phase_step;
      REG_MIX_GAIN:    prdata = {16'd0, cfg_q.mix_gain};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_delay  <= BASE_DELAY_RST;
      cfg_q.sweep_depth <= SWEEP_DEPTH_RST;
      cfg_q.phase_step  <= PHASE_STEP_RST;
      cfg_q.mix_gain    <= MIX_GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/mdf_dp.sv]
// Flanger datapath: delay ring, LFO, tap address, gain multiply and output register.
// Depends on mdf_pkg and assert_macros.svh; sequenced by mdf_ctrl.
`include "assert_macros.svh"
module mdf_dp #(
  parameter int RING_DEPTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdf_pkg::cfg_t    cfg_i,
  input  mdf_pkg::dp_cmd_t cmd_i,
  output mdf_pkg::dp_sts_t sts_o,
  input  logic [15:0]      sample_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      sample_out_o
);
  import mdf_pkg::*;

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam logic [ADDR_W-1:0] WP_LAST   = ADDR_W'(RING_DEPTH - 1);
  localparam logic [ADDR_W-1:0] DEPTH_ADD = ADDR_W'(RING_DEPTH);
  localparam logic signed [17:0] OFF_MAX  = 18'(RING_DEPTH - 1);

  logic [15:0] ring_mem [RING_DEPTH];

  // Control state
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [31:0]       phase_q, phase_d;
  logic [10:0]       warm_cnt_q, warm_cnt_d;
  logic              out_valid_q, out_valid_d;

  // Per-item working registers
  logic [15:0]        x_q;
  logic [ADDR_W-1:0]  item_wp_q;
  logic               pass_q;
  logic               neg_q;
  logic [COS_W-1:0]   cos_mag_q;
  logic signed [26:0] prod_q;
  logic [15:0]        delayed_q;
  logic signed [32:0] gain_q;
  logic [15:0]        out_data_q;

  logic [10:0]            threshold;
  logic                   pass_d;
  logic [PHASE_POS_W-1:0] lfo_pos;
  logic [1:0]             quad;
  logic [COS_IDX_W-2:0]   frac;
  logic [COS_IDX_W-1:0]   tab_idx;
  logic signed [15:0]     cos_s;
  logic signed [26:0]     prod_d;
  logic signed [17:0]     off_s;
  logic [ADDR_W-1:0]      off_c;
  logic [ADDR_W:0]        diff;
  logic [ADDR_W-1:0]      rd_idx;
  logic signed [32:0]     gain_d;
  logic signed [18:0]     rnd;
  logic signed [19:0]     sum;
  logic [15:0]            sat;

  // Write pointer, warm-up and LFO bookkeeping at the input transfer
  always_comb begin
    threshold  = {1'b0, cfg_i.base_delay} + {1'b0, cfg_i.sweep_depth};
    pass_d     = warm_cnt_q < threshold;
    wp_d       = wp_q;
    phase_d    = phase_q;
    warm_cnt_d = warm_cnt_q;
    if (cmd_i.accept) begin
      wp_d    = (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
      phase_d = phase_q + cfg_i.phase_step;
      if (pass_d) begin
        warm_cnt_d = warm_cnt_q + 11'd1;
      end
    end
  end

  // Quarter-wave folding: odd quadrants read the table backwards.
  always_comb begin
    lfo_pos = phase_q[31 -: PHASE_POS_W];
    quad    = lfo_pos[PHASE_POS_W-1 -: 2];
    frac    = lfo_pos[PHASE_POS_W-3:0];
    tab_idx = quad[0] ? COS_IDX_W'(COS_N) - {1'b0, frac} : {1'b0, frac};
  end

  always_comb begin
    cos_s  = neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});
    prod_d = 27'(cos_s) * 27'($signed({1'b0, cfg_i.sweep_depth}));
  end

  // Tap offset is floor(cos * depth / 32768) + base, clamped to the ring.
  always_comb begin
    off_s = $signed({{6{prod_q[26]}}, prod_q[26:15]}) + $signed({8'd0, cfg_i.base_delay});
    if (off_s[17]) begin
      off_c = '0;
    end else if (off_s > OFF_MAX) begin
      off_c = WP_LAST;
    end else begin
      off_c = off_s[ADDR_W-1:0];
    end
    diff   = {1'b0, item_wp_q} - {1'b0, off_c};
    rd_idx = diff[ADDR_W] ? diff[ADDR_W-1:0] + DEPTH_ADD : diff[ADDR_W-1:0];
  end

  always_comb begin
    gain_d = 33'($signed({1'b0, cfg_i.mix_gain})) * 33'($signed(delayed_q));
    rnd    = 19'((gain_q + 33'sd8192) >>> 14);
    sum    = 20'($signed(x_q)) + 20'(rnd);
    if (sum > 20'sd32767) begin
      sat = 16'h7fff;
    end else if (sum < -20'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = sum[15:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      phase_q     <= '0;
      warm_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      phase_q     <= phase_d;
      warm_cnt_q  <= warm_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q       <= sample_in_i;
      item_wp_q <= wp_q;
      pass_q    <= pass_d;
      neg_q     <= quad[1] ^ quad[0];
      cos_mag_q <= COS_TAB[tab_idx];
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.gain_en) begin
      gain_q <= gain_d;
    end
    if (cmd_i.out_load) begin
      out_data_q <= pass_q ? x_q : sat;
    end
  end

  // Ring write at the input transfer, registered tap read later.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_mem[wp_q] <= sample_in_i;
    end
    if (cmd_i.tap_en) begin
      delayed_q <= ring_mem[rd_idx];
    end
  end

  `ASSERT_NEVER(a_no_overwrite, cmd_i.out_load && out_valid_q && out_stall_i, clk_i, rst_ni)
  `ASSERT_PROP(a_wp_in_ring, {1'b0, wp_q} < (ADDR_W + 1)'(RING_DEPTH), clk_i, rst_ni)
  `ASSERT_PROP(a_warm_bound, warm_cnt_q <= 11'd2046, clk_i, rst_ni)

endmodule

[rtl/mdf_ctrl.sv]
// Flanger controller: steps one sample through the datapath phases.
// Depends on mdf_pkg and assert_macros.svh; drives mdf_dp.
`include "assert_macros.svh"
module mdf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mdf_pkg::dp_sts_t sts_i,
  output mdf_pkg::dp_cmd_t cmd_o
);
  import mdf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_TAP;
      end
      ST_TAP: begin
        cmd_o.tap_en = 1'b1;
        state_d      = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain_en = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here only while the output register is still held.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_PROP(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o, clk_i, rst_ni)
  `ASSERT_PROP(a_mul_follows, cmd_o.accept |=> cmd_o.mul_en, clk_i, rst_ni)

endmodule
